// File: rtl/msk_pkg.sv
// ----------------------------------------------------------------------------
// msk_pkg: shared definitions of the MessagePack element skipper
// Lead byte classes, header kinds, status codes and the queue entry type.
// ----------------------------------------------------------------------------
package msk_pkg;

  localparam int QUEUE_DEPTH = 4;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_INVALID  = 2'd1,
    ST_TRUNC    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  // What a byte means if it turns out to be a lead byte.
  typedef enum logic [1:0] {
    CLS_PAY = 2'd0,   // fixed payload follows (possibly none)
    CLS_HDR = 2'd1,   // big-endian header follows
    CLS_ADD = 2'd2,   // fixarray or fixmap: adds elements directly
    CLS_INV = 2'd3    // reserved lead byte
  } lead_cls_t;

  // Kind of header being collected.
  typedef enum logic [2:0] {
    HK_NONE    = 3'd0,
    HK_LEN     = 3'd1,
    HK_LIST    = 3'd2,
    HK_MAP     = 3'd3,
    HK_FIXEXT1 = 3'd4,
    HK_FIXEXT2 = 3'd5,
    HK_EXT     = 3'd6
  } hdr_kind_t;

  // One classified byte as it travels from the front to the back.
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    lead_cls_t  cls;
    logic [4:0] len;     // payload length or element increment
    hdr_kind_t  hkind;
    logic [2:0] hlen;    // header length in bytes
  } msk_entry_t;

endpackage

// File: rtl/msk_front.sv
// ----------------------------------------------------------------------------
// msk_front: input side of the element skipper
// Accepts bytes and classifies each one as a potential lead byte.
// ----------------------------------------------------------------------------
module msk_front (
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_data,
  input  logic              in_first,
  input  logic              in_last,
  input  logic              q_full,
  output logic              q_push,
  output msk_pkg::msk_entry_t q_wdata
);
  import msk_pkg::*;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_wdata       = '0;
    q_wdata.data  = in_data;
    q_wdata.first = in_first;
    q_wdata.last  = in_last;
    q_wdata.cls   = CLS_PAY;
    q_wdata.hkind = HK_NONE;
    case (in_data)
      8'hc0, 8'hc2, 8'hc3: q_wdata.len = 5'd0;
      8'hc1: q_wdata.cls = CLS_INV;
      8'hcc, 8'hd0: q_wdata.len = 5'd1;
      8'hcd, 8'hd1: q_wdata.len = 5'd2;
      8'hca, 8'hce, 8'hd2: q_wdata.len = 5'd4;
      8'hcb, 8'hcf, 8'hd3: q_wdata.len = 5'd8;
      8'hd6: q_wdata.len = 5'd5;
      8'hd7: q_wdata.len = 5'd9;
      8'hd8: q_wdata.len = 5'd17;
      8'hc4, 8'hd9: begin
        q_wdata.cls = CLS_HDR; q_wdata.hkind = HK_LEN; q_wdata.hlen = 3'd1;
      end
      8'hc5, 8'hda: begin
        q_wdata.cls = CLS_HDR; q_wdata.hkind = HK_LEN; q_wdata.hlen = 3'd2;
      end
      8'hc6, 8'hdb: begin
        q_wdata.cls = CLS_HDR; q_wdata.hkind = HK_LEN; q_wdata.hlen = 3'd4;
      end
      8'hdc: begin
        q_wdata.cls = CLS_HDR; q_wdata.hkind = HK_LIST; q_wdata.hlen = 3'd2;
      end
      8'hdd: begin
        q_wdata.cls = CLS_HDR; q_wdata.hkind = HK_LIST; q_wdata.hlen = 3'd4;
      end
      8'hde: begin
        q_wdata.cls = CLS_HDR; q_wdata.hkind = HK_MAP; q_wdata.hlen = 3'd2;
      end
      8'hdf: begin
        q_wdata.cls = CLS_HDR; q_wdata.hkind = HK_MAP; q_wdata.hlen = 3'd4;
      end
      8'hd4: begin
        q_wdata.cls = CLS_HDR; q_wdata.hkind = HK_FIXEXT1; q_wdata.hlen = 3'd1;
      end
      8'hd5: begin
        q_wdata.cls = CLS_HDR; q_wdata.hkind = HK_FIXEXT2; q_wdata.hlen = 3'd1;
      end
      8'hc7: begin
        q_wdata.cls = CLS_HDR; q_wdata.hkind = HK_EXT; q_wdata.hlen = 3'd2;
      end
      8'hc8: begin
        q_wdata.cls = CLS_HDR; q_wdata.hkind = HK_EXT; q_wdata.hlen = 3'd3;
      end
      8'hc9: begin
        q_wdata.cls = CLS_HDR; q_wdata.hkind = HK_EXT; q_wdata.hlen = 3'd5;
      end
      default: begin
        if (in_data inside {[8'ha0:8'hbf]}) begin
          q_wdata.len = in_data[4:0];
        end else if (in_data inside {[8'h80:8'h8f]}) begin
          // A fixmap adds two elements per pair.
          q_wdata.cls = CLS_ADD;
          q_wdata.len = {in_data[3:0], 1'b0};
        end else if (in_data inside {[8'h90:8'h9f]}) begin
          q_wdata.cls = CLS_ADD;
          q_wdata.len = {1'b0, in_data[3:0]};
        end
      end
    endcase
  end

endmodule

// File: rtl/msk_queue.sv
// ----------------------------------------------------------------------------
// msk_queue: short queue between front and back
// Holds classified bytes so that either side can stall on its own.
// ----------------------------------------------------------------------------
module msk_queue #(
  parameter int DEPTH = msk_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  msk_pkg::msk_entry_t wdata,
  output logic                full,
  input  logic                pop,
  output logic                valid,
  output msk_pkg::msk_entry_t rdata
);
  import msk_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  msk_entry_t       entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign valid = (count_r != '0);
  assign rdata = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: rtl/msk_back.sv
// ----------------------------------------------------------------------------
// msk_back: parse engine of the element skipper
// Tracks pending elements, headers and payload skips, and registers results.
// ----------------------------------------------------------------------------
module msk_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [31:0]         element_count,
  input  logic                q_valid,
  input  msk_pkg::msk_entry_t q_rdata,
  output logic                q_pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [1:0]          out_status,
  output logic [31:0]         out_size,
  output logic                out_nonstorage
);
  import msk_pkg::*;

  logic        active_r, active_nxt;
  logic [31:0] pend_r, pend_nxt;
  logic [2:0]  hbl_r, hbl_nxt;
  logic [31:0] hval_r, hval_nxt;
  hdr_kind_t   hkind_r, hkind_nxt;
  logic [31:0] pay_r, pay_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic        ns_r, ns_nxt;

  logic        ovalid_r, ovalid_nxt;
  status_t     ostatus_r, ostatus_nxt;
  logic [31:0] osize_r, osize_nxt;
  logic        ons_r, ons_nxt;

  logic        res_valid;
  logic        err;
  status_t     err_code;
  logic [33:0] sum;

  assign q_pop          = q_valid && (!ovalid_r || out_tready);
  assign out_tvalid     = ovalid_r;
  assign out_status     = ostatus_r;
  assign out_size       = osize_r;
  assign out_nonstorage = ons_r;

  always_comb begin
    active_nxt = active_r;
    pend_nxt   = pend_r;
    hbl_nxt    = hbl_r;
    hval_nxt   = hval_r;
    hkind_nxt  = hkind_r;
    pay_nxt    = pay_r;
    cnt_nxt    = cnt_r;
    ns_nxt     = ns_r;
    res_valid  = 1'b0;
    err        = 1'b0;
    err_code   = ST_INVALID;
    sum        = '0;
    ostatus_nxt = ostatus_r;
    osize_nxt   = osize_r;
    ons_nxt     = ons_r;

    if (q_pop) begin
      if (q_rdata.first) begin
        active_nxt = 1'b1;
        pend_nxt   = element_count;
        hbl_nxt    = '0;
        hval_nxt   = '0;
        hkind_nxt  = HK_NONE;
        pay_nxt    = '0;
        cnt_nxt    = '0;
        ns_nxt     = 1'b0;
        // An empty parse answers at once with size zero and does not count the byte.
        if (element_count == '0) begin
          active_nxt  = 1'b0;
          res_valid   = 1'b1;
          ostatus_nxt = ST_DONE;
          osize_nxt   = '0;
          ons_nxt     = 1'b0;
        end
      end

      if (active_nxt) begin
        cnt_nxt = cnt_nxt + 1'b1;
        if (pay_nxt != '0) begin
          pay_nxt = pay_nxt - 1'b1;
        end else if (hbl_nxt != '0) begin
          hbl_nxt = hbl_nxt - 1'b1;
          // The last byte of an ext header is the type, not part of the length.
          if (!((hkind_nxt == HK_EXT || hkind_nxt == HK_FIXEXT1 ||
                 hkind_nxt == HK_FIXEXT2) && hbl_nxt == '0)) begin
            hval_nxt = {hval_nxt[23:0], q_rdata.data};
          end
          if (hbl_nxt == '0) begin
            case (hkind_nxt)
              HK_LEN: pay_nxt = hval_nxt;
              HK_LIST: begin
                sum = {2'b00, pend_nxt} + {2'b00, hval_nxt};
                if (sum[33:32] != 2'b00) begin
                  err = 1'b1; err_code = ST_OVERFLOW;
                end else begin
                  pend_nxt = sum[31:0];
                end
              end
              HK_MAP: begin
                sum = {2'b00, pend_nxt} + {1'b0, hval_nxt, 1'b0};
                if (sum[33:32] != 2'b00) begin
                  err = 1'b1; err_code = ST_OVERFLOW;
                end else begin
                  pend_nxt = sum[31:0];
                end
              end
              HK_FIXEXT1, HK_FIXEXT2: begin
                if (q_rdata.data == 8'hff) ns_nxt = 1'b1;
                pay_nxt = (hkind_nxt == HK_FIXEXT1) ? 32'd1 : 32'd2;
              end
              default: begin
                if (q_rdata.data == 8'hff && hval_nxt != '0 && hval_nxt < 32'd4) begin
                  ns_nxt = 1'b1;
                end
                pay_nxt = hval_nxt;
              end
            endcase
            hkind_nxt = HK_NONE;
          end
        end else begin
          pend_nxt = pend_nxt - 1'b1;
          case (q_rdata.cls)
            CLS_INV: begin
              err = 1'b1; err_code = ST_INVALID;
            end
            CLS_PAY: pay_nxt = {27'd0, q_rdata.len};
            CLS_HDR: begin
              hkind_nxt = q_rdata.hkind;
              hbl_nxt   = q_rdata.hlen;
              hval_nxt  = '0;
            end
            default: begin
              sum = {2'b00, pend_nxt} + {29'd0, q_rdata.len};
              if (sum[33:32] != 2'b00) begin
                err = 1'b1; err_code = ST_OVERFLOW;
              end else begin
                pend_nxt = sum[31:0];
              end
            end
          endcase
        end

        if (err) begin
          res_valid   = 1'b1;
          ostatus_nxt = err_code;
          osize_nxt   = '0;
          ons_nxt     = 1'b0;
        end else if (hbl_nxt == '0 && pay_nxt == '0 && pend_nxt == '0) begin
          res_valid   = 1'b1;
          ostatus_nxt = ST_DONE;
          osize_nxt   = cnt_nxt;
          ons_nxt     = ns_nxt;
        end else if (q_rdata.last) begin
          res_valid   = 1'b1;
          ostatus_nxt = ST_TRUNC;
          osize_nxt   = '0;
          ons_nxt     = 1'b0;
        end
        if (res_valid) active_nxt = 1'b0;
      end
    end

    if (res_valid) begin
      ovalid_nxt = 1'b1;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end else begin
      ovalid_nxt = ovalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pend_r   <= '0;
      hbl_r    <= '0;
      hval_r   <= '0;
      hkind_r  <= HK_NONE;
      pay_r    <= '0;
      cnt_r    <= '0;
      ns_r     <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      pend_r   <= pend_nxt;
      hbl_r    <= hbl_nxt;
      hval_r   <= hval_nxt;
      hkind_r  <= hkind_nxt;
      pay_r    <= pay_nxt;
      cnt_r    <= cnt_nxt;
      ns_r     <= ns_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ostatus_r <= ostatus_nxt;
    osize_r   <= osize_nxt;
    ons_r     <= ons_nxt;
  end

  // A running parse always has something left to skip.
  a_active_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (pend_r != '0 || hbl_r != '0 || pay_r != '0))
    else $error("active parse with nothing pending");

  // Header collection and payload skipping never overlap.
  a_hdr_pay_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(hbl_r != '0 && pay_r != '0))
    else $error("header and payload counters both running");

  // Every result closes the parse.
  a_result_ends_parse: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> !active_r)
    else $error("parse still active after a result");

  // A byte is never taken while a finished result would be overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !out_tready) |-> !q_pop)
    else $error("byte processed while result stalled");

endmodule

// File: rtl/msgpack_element_skipper.sv
// ----------------------------------------------------------------------------
// msgpack_element_skipper: MessagePack element skip parser
// Skips a configured number of top-level elements of a byte stream.
// ----------------------------------------------------------------------------
// The block takes one MessagePack byte per cycle while the queue has room,
// which it keeps unless a result waits on out_tready: every byte is
// classified on entry, passes a short queue and is applied by the back end
// to the pending, header and payload counters. A result is offered once the
// byte that causes it is transferred (the byte is written into the queue,
// then the result into the output register), and input transfers continue
// while a result waits, until the queue fills. A byte with tuser set starts
// a parse; tlast marks the final byte of the buffer. element_count is written
// through cfg_we/cfg_wdata and resets to 1; the user must write it only while
// the block is idle, which the block itself does not enforce.
module msgpack_element_skipper #(
  parameter int QUEUE_DEPTH = msk_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,     // element_count
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] data_byte
  input  logic        in_tuser,      // [0] first_byte
  input  logic        in_tlast,      // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata      // [1:0] status, [33:2] consumed_size,
                                     // [34] nonstorage_seen, [39:35] zero
);
  import msk_pkg::*;

  logic [31:0] element_count_r;
  logic        q_full, q_push, q_valid, q_pop;
  msk_entry_t  q_wdata, q_rdata;
  logic [1:0]  res_status;
  logic [31:0] res_size;
  logic        res_ns;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      element_count_r <= 32'd1;
    end else if (cfg_we) begin
      element_count_r <= cfg_wdata;
    end
  end

  msk_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_data   (in_tdata),
    .in_first  (in_tuser),
    .in_last   (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  msk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  msk_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .element_count  (element_count_r),
    .q_valid        (q_valid),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_status     (res_status),
    .out_size       (res_size),
    .out_nonstorage (res_ns)
  );

  assign out_tdata = {5'd0, res_ns, res_size, res_status};

endmodule
